/* rtl/ecb_pkg.sv */
// Shared types and constants for the epoch grace period callback table.
package ecb_pkg;

    localparam int HANDLE_W = 64;
    localparam int EPOCH_W = 64;
    localparam int READER_W = 32;
    localparam int KIND_W = 3;
    localparam int STATUS_W = 3;
    localparam int COUNT_W = 7;
    localparam int MAX_RESULTS = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;

    // Input item kinds.
    localparam logic [KIND_W-1:0] KIND_LOCK     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_UNLOCK   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REGISTER = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TICK     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PROCESS  = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NO_READER = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_READERS   = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_RELEASED  = 3'd5;
    localparam logic [STATUS_W-1:0] STATUS_NONE      = 3'd6;

    // Operations after classification.
    typedef enum logic [2:0] {
        OP_LOCK,
        OP_UNLOCK,
        OP_REG,
        OP_NULL,
        OP_TICK,
        OP_PROC,
        OP_IGNORE
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [HANDLE_W-1:0] handle;
        logic [HANDLE_W-1:0] argument;
    } cmd_t;

    typedef struct packed {
        logic                valid;
        logic [HANDLE_W-1:0] handle;
        logic [HANDLE_W-1:0] argument;
        logic [EPOCH_W-1:0]  epoch;
    } slot_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SCAN_REG,
        BK_SCAN_PROC,
        BK_FINISH
    } back_state_t;

endpackage

/* rtl/ecb_front.sv */
// Front end: accepts input beats and classifies them into queue commands.
module ecb_front (
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ecb_pkg::KIND_W-1:0]      kind,
    input  logic [ecb_pkg::HANDLE_W-1:0]    callback_handle,
    input  logic [ecb_pkg::HANDLE_W-1:0]    callback_argument,
    input  logic                            q_full,
    input  logic                            clearing,
    output logic                            push,
    output ecb_pkg::cmd_t                   push_cmd
);

    ecb_pkg::op_t op;

    always_comb
    begin
        case (kind)
            ecb_pkg::KIND_LOCK:     op = ecb_pkg::OP_LOCK;
            ecb_pkg::KIND_UNLOCK:   op = ecb_pkg::OP_UNLOCK;
            ecb_pkg::KIND_REGISTER:
            begin
                // A null handle is rejected without touching the table.
                if (callback_handle == '0)
                    op = ecb_pkg::OP_NULL;
                else
                    op = ecb_pkg::OP_REG;
            end
            ecb_pkg::KIND_TICK:     op = ecb_pkg::OP_TICK;
            ecb_pkg::KIND_PROCESS:  op = ecb_pkg::OP_PROC;
            default:                op = ecb_pkg::OP_IGNORE;
        endcase
    end

    assign in_stall = q_full | clearing;
    assign push = in_valid & ~in_stall;
    assign push_cmd.op = op;
    assign push_cmd.handle = callback_handle;
    assign push_cmd.argument = callback_argument;

endmodule

/* rtl/ecb_queue.sv */
// Short command queue between the front end and the back end.
module ecb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ecb_pkg::cmd_t   push_cmd,
    input  logic            pop,
    output ecb_pkg::cmd_t   head,
    output logic            not_empty,
    output logic            full
);

    localparam int CNT_W = ecb_pkg::QPTR_W + 1;

    ecb_pkg::cmd_t                entry_reg [ecb_pkg::QUEUE_DEPTH];
    logic [ecb_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [ecb_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;

    assign not_empty = count_reg != '0;
    assign full = count_reg == CNT_W'(ecb_pkg::QUEUE_DEPTH);
    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* rtl/ecb_back.sv */
// Back end: reader count, epoch, callback table memory, scan sequencer and result register.
module ecb_back #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ecb_pkg::cmd_t                     cmd,
    input  logic                              cmd_valid,
    output logic                              cmd_pop,
    output logic                              clearing,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ecb_pkg::STATUS_W-1:0]      status,
    output logic [ecb_pkg::HANDLE_W-1:0]      released_handle,
    output logic [ecb_pkg::HANDLE_W-1:0]      released_argument,
    output logic [ecb_pkg::COUNT_W-1:0]       released_count,
    output logic                              last_of_run
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Callback table memory: one write port, one registered read port.
    ecb_pkg::slot_t mem [TABLE_DEPTH];
    ecb_pkg::slot_t rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    ecb_pkg::slot_t   mem_wdata;

    ecb_pkg::back_state_t state_reg, state_next;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [ecb_pkg::COUNT_W-1:0]    n_reg, n_next;
    logic [ecb_pkg::READER_W-1:0]   readers_reg, readers_next;
    logic [ecb_pkg::EPOCH_W-1:0]    epoch_reg, epoch_next;
    logic [ecb_pkg::HANDLE_W-1:0]   cmd_handle_reg, cmd_handle_next;
    logic [ecb_pkg::HANDLE_W-1:0]   cmd_arg_reg, cmd_arg_next;
    logic [ecb_pkg::HANDLE_W-1:0]   pend_handle_reg, pend_handle_next;
    logic [ecb_pkg::HANDLE_W-1:0]   pend_arg_reg, pend_arg_next;

    logic                           out_valid_reg;
    logic [ecb_pkg::STATUS_W-1:0]   out_status_reg;
    logic [ecb_pkg::HANDLE_W-1:0]   out_handle_reg;
    logic [ecb_pkg::HANDLE_W-1:0]   out_arg_reg;
    logic [ecb_pkg::COUNT_W-1:0]    out_count_reg;
    logic                           out_last_reg;

    logic                           out_free;
    logic                           emit;
    logic [ecb_pkg::STATUS_W-1:0]   e_status;
    logic [ecb_pkg::HANDLE_W-1:0]   e_handle;
    logic [ecb_pkg::HANDLE_W-1:0]   e_arg;
    logic [ecb_pkg::COUNT_W-1:0]    e_count;
    logic                           e_last;
    logic                           match;
    logic [ecb_pkg::COUNT_W-1:0]    n_inc;

    assign out_free = ~out_valid_reg | ~out_stall;
    assign match = rd_data_reg.valid && (rd_data_reg.epoch < epoch_reg);
    assign n_inc = n_reg + 1'b1;
    assign clearing = state_reg == ecb_pkg::BK_CLEAR;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        n_next = n_reg;
        readers_next = readers_reg;
        epoch_next = epoch_reg;
        cmd_handle_next = cmd_handle_reg;
        cmd_arg_next = cmd_arg_reg;
        pend_handle_next = pend_handle_reg;
        pend_arg_next = pend_arg_reg;
        cmd_pop = 1'b0;
        rd_addr = idx_reg;
        mem_we = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = rd_data_reg;
        emit = 1'b0;
        e_status = ecb_pkg::STATUS_OK;
        e_handle = '0;
        e_arg = '0;
        e_count = '0;
        e_last = 1'b1;

        case (state_reg)
            ecb_pkg::BK_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wdata.valid = 1'b0;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next = '0;
                    state_next = ecb_pkg::BK_IDLE;
                end
            end

            ecb_pkg::BK_IDLE:
            begin
                rd_addr = '0;
                idx_next = '0;
                n_next = '0;
                if (cmd_valid)
                begin
                    case (cmd.op)
                        ecb_pkg::OP_REG:
                        begin
                            cmd_pop = 1'b1;
                            cmd_handle_next = cmd.handle;
                            cmd_arg_next = cmd.argument;
                            state_next = ecb_pkg::BK_SCAN_REG;
                        end
                        ecb_pkg::OP_PROC:
                        begin
                            if (readers_reg != '0)
                            begin
                                if (out_free)
                                begin
                                    cmd_pop = 1'b1;
                                    emit = 1'b1;
                                    e_status = ecb_pkg::STATUS_READERS;
                                end
                            end
                            else
                            begin
                                cmd_pop = 1'b1;
                                state_next = ecb_pkg::BK_SCAN_PROC;
                            end
                        end
                        ecb_pkg::OP_LOCK:
                        begin
                            if (out_free)
                            begin
                                cmd_pop = 1'b1;
                                emit = 1'b1;
                                if (readers_reg != '1)
                                    readers_next = readers_reg + 1'b1;
                            end
                        end
                        ecb_pkg::OP_UNLOCK:
                        begin
                            if (out_free)
                            begin
                                cmd_pop = 1'b1;
                                emit = 1'b1;
                                if (readers_reg == '0)
                                    e_status = ecb_pkg::STATUS_NO_READER;
                                else
                                    readers_next = readers_reg - 1'b1;
                            end
                        end
                        ecb_pkg::OP_TICK:
                        begin
                            if (out_free)
                            begin
                                cmd_pop = 1'b1;
                                emit = 1'b1;
                                epoch_next = epoch_reg + 1'b1;
                            end
                        end
                        ecb_pkg::OP_NULL:
                        begin
                            if (out_free)
                            begin
                                cmd_pop = 1'b1;
                                emit = 1'b1;
                                e_status = ecb_pkg::STATUS_NULL;
                            end
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                cmd_pop = 1'b1;
                                emit = 1'b1;
                            end
                        end
                    endcase
                end
            end

            ecb_pkg::BK_SCAN_REG:
            begin
                if (!rd_data_reg.valid)
                begin
                    // Lowest free slot found: store the callback here.
                    if (out_free)
                    begin
                        mem_we = 1'b1;
                        mem_wdata.valid = 1'b1;
                        mem_wdata.handle = cmd_handle_reg;
                        mem_wdata.argument = cmd_arg_reg;
                        mem_wdata.epoch = epoch_reg;
                        emit = 1'b1;
                        state_next = ecb_pkg::BK_IDLE;
                    end
                end
                else if (idx_reg == LAST_IDX)
                begin
                    if (out_free)
                    begin
                        emit = 1'b1;
                        e_status = ecb_pkg::STATUS_FULL;
                        state_next = ecb_pkg::BK_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_addr = idx_next;
                end
            end

            ecb_pkg::BK_SCAN_PROC:
            begin
                if (match)
                begin
                    // The previous release goes out now; this one is held
                    // until it is known whether it ends the run.
                    if (n_reg == '0 || out_free)
                    begin
                        if (n_reg != '0)
                        begin
                            emit = 1'b1;
                            e_status = ecb_pkg::STATUS_RELEASED;
                            e_handle = pend_handle_reg;
                            e_arg = pend_arg_reg;
                            e_count = n_reg;
                            e_last = 1'b0;
                        end
                        mem_we = 1'b1;
                        mem_wdata.valid = 1'b0;
                        pend_handle_next = rd_data_reg.handle;
                        pend_arg_next = rd_data_reg.argument;
                        n_next = n_inc;
                        if (n_inc == ecb_pkg::COUNT_W'(ecb_pkg::MAX_RESULTS)
                            || idx_reg == LAST_IDX)
                            state_next = ecb_pkg::BK_FINISH;
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                            rd_addr = idx_next;
                        end
                    end
                end
                else if (idx_reg == LAST_IDX)
                    state_next = ecb_pkg::BK_FINISH;
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_addr = idx_next;
                end
            end

            ecb_pkg::BK_FINISH:
            begin
                rd_addr = '0;
                if (out_free)
                begin
                    emit = 1'b1;
                    if (n_reg != '0)
                    begin
                        e_status = ecb_pkg::STATUS_RELEASED;
                        e_handle = pend_handle_reg;
                        e_arg = pend_arg_reg;
                        e_count = n_reg;
                    end
                    else
                        e_status = ecb_pkg::STATUS_NONE;
                    n_next = '0;
                    idx_next = '0;
                    state_next = ecb_pkg::BK_IDLE;
                end
            end

            default:
            begin
                state_next = ecb_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ecb_pkg::BK_CLEAR;
            idx_reg <= '0;
            n_reg <= '0;
            readers_reg <= '0;
            epoch_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            n_reg <= n_next;
            readers_reg <= readers_next;
            epoch_reg <= epoch_next;
            out_valid_reg <= emit | (out_valid_reg & out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_handle_reg <= cmd_handle_next;
        cmd_arg_reg <= cmd_arg_next;
        pend_handle_reg <= pend_handle_next;
        pend_arg_reg <= pend_arg_next;
        if (emit)
        begin
            out_status_reg <= e_status;
            out_handle_reg <= e_handle;
            out_arg_reg <= e_arg;
            out_count_reg <= e_count;
            out_last_reg <= e_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign status = out_status_reg;
    assign released_handle = out_handle_reg;
    assign released_argument = out_arg_reg;
    assign released_count = out_count_reg;
    assign last_of_run = out_last_reg;

endmodule

/* rtl/epoch_grace_period_callback_table_top.sv */
// Top level of the epoch grace period callback table.
//
//   Channel  Direction  Handshake           Beat contents
//   in       input      in_valid/in_stall   kind, callback_handle, callback_argument
//   out      output     out_valid/out_stall status, released_handle, released_argument,
//                                           released_count, last_of_run
//
// After reset the back end runs a clearing pass that marks every slot free;
// in_stall stays high until it ends.
// Lock, unlock, tick, null register and unused kinds are handled from the idle state.
// A register scans the slot memory one entry per cycle from slot 0 and stores the
// callback in the lowest free slot, or reports full when no slot is free.
// A process scans the slots through the memory read port, one per cycle while out_stall
// does not hold a result, and stops after MAX_RESULTS releases or at the last slot.
// The two-entry command queue lets the front keep taking beats while the back works.
module epoch_grace_period_callback_table_top #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ecb_pkg::KIND_W-1:0]      kind,
    input  logic [ecb_pkg::HANDLE_W-1:0]    callback_handle,
    input  logic [ecb_pkg::HANDLE_W-1:0]    callback_argument,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ecb_pkg::STATUS_W-1:0]    status,
    output logic [ecb_pkg::HANDLE_W-1:0]    released_handle,
    output logic [ecb_pkg::HANDLE_W-1:0]    released_argument,
    output logic [ecb_pkg::COUNT_W-1:0]     released_count,
    output logic                            last_of_run
);

    // Commands between the front end, the queue and the back end.
    logic           push;
    ecb_pkg::cmd_t  push_cmd;
    logic           pop;
    ecb_pkg::cmd_t  head;
    logic           not_empty;
    logic           q_full;
    logic           clearing;

    // The front end only decodes the kind and flags a null handle; all table
    // state lives in the back end so that items take effect in arrival order.
    ecb_front u_front (
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .kind              (kind),
        .callback_handle   (callback_handle),
        .callback_argument (callback_argument),
        .q_full            (q_full),
        .clearing          (clearing),
        .push              (push),
        .push_cmd          (push_cmd)
    );

    ecb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .full      (q_full)
    );

    // The back end holds one release result back so that it can mark the
    // final release of a pass as last of the run once the scan has ended.
    ecb_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (head),
        .cmd_valid         (not_empty),
        .cmd_pop           (pop),
        .clearing          (clearing),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .released_handle   (released_handle),
        .released_argument (released_argument),
        .released_count    (released_count),
        .last_of_run       (last_of_run)
    );

endmodule
